// File: src/ulr_pkg.sv
package ulr_pkg;

    // Field widths
    localparam int FRAC_BITS    = 24;
    localparam int UPPER_BITS   = 29;
    localparam int SEED_BITS    = 30;
    localparam int PROD_BITS    = FRAC_BITS + UPPER_BITS;
    localparam int LAG_ENTRIES  = 97;
    localparam int IDX_BITS     = 7;

    // Quotient length of the seed split and reciprocal shifts
    localparam int SPLIT_Q_BITS = 15;
    localparam int SPLIT_SHIFT  = 45;
    localparam int SMALL_SHIFT  = 23;

    typedef enum logic {
        OP_SEED = 1'b0,
        OP_DRAW = 1'b1
    } t_op;

    typedef logic [FRAC_BITS-1:0]  t_frac;
    typedef logic [UPPER_BITS-1:0] t_upper;
    typedef logic [SEED_BITS-1:0]  t_seed;
    typedef logic [IDX_BITS-1:0]   t_idx;

    // Seed handling
    localparam t_seed      SEED_MAX   = 30'd900000000;
    localparam logic [14:0] SEED_SPLIT = 15'd30082;
    localparam logic [7:0] SPLIT_IJ   = 8'd177;
    localparam logic [7:0] MOD_LFG    = 8'd179;
    localparam logic [7:0] MOD_LCG    = 8'd169;
    localparam logic [7:0] LCG_MUL    = 8'd53;

    // Rounded-up reciprocals, exact for every quotient the seed split needs
    localparam logic [31:0] SPLIT_RECIP = 32'(((64'd1 << SPLIT_SHIFT)
        + 64'(SEED_SPLIT) - 64'd1) / 64'(SEED_SPLIT));
    localparam logic [15:0] IJ_RECIP    = 16'(((32'd1 << SMALL_SHIFT)
        + 32'(SPLIT_IJ) - 32'd1) / 32'(SPLIT_IJ));
    localparam logic [15:0] KL_RECIP    = 16'(((32'd1 << SMALL_SHIFT)
        + 32'(MOD_LCG) - 32'd1) / 32'(MOD_LCG));

    // Carry sequence
    localparam t_frac CARRY_INIT = 24'd362436;
    localparam t_frac CARRY_DEC  = 24'd7654321;
    localparam t_frac CARRY_MOD  = 24'd16777213;

    // Lag positions run 1..97
    localparam t_idx LAG_LAST        = 7'd97;
    localparam t_idx SECOND_LAG_INIT = 7'd33;

endpackage

// File: src/ulr_if.sv
interface ulr_req_if import ulr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_op    operation;
    t_seed  seed_value;
    t_upper upper_limit;

    modport source (output valid, output operation, output seed_value, output upper_limit,
                    input ready);
    modport sink   (input valid, input operation, input seed_value, input upper_limit,
                    output ready);
endinterface

interface ulr_rsp_if import ulr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frac  uniform_fraction;
    t_upper scaled_integer;
    logic   error_flag;

    modport source (output valid, output uniform_fraction, output scaled_integer,
                    output error_flag, input ready);
    modport sink   (input valid, input uniform_fraction, input scaled_integer,
                    input error_flag, output ready);
endinterface

// File: src/ulr_ram.sv
module ulr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 97
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read two with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// File: src/universal_lagged_rng_generator.sv
// Channel | Dir | Beat contents
// i_req   | in  | operation, seed_value, upper_limit
// o_rsp   | out | uniform_fraction, scaled_integer, error_flag
//
// A draw passes through a registered table read, a subtract and write-back, a 24x29
// multiply and a rounding stage. A valid seed is split by reciprocal multiplies in
// DIV_SEED, DIV_IJ, DIV_KL and DIV_END, then 97 x 24 table bits pass through the
// mod-179 multiply loop, each in a multiply state and a reduce state. Errors and
// rejected seeds go straight to the output stage. Reset clears the control state only;
// the lag table holds garbage until the first seed. A result stalled at o_rsp
// holds the block in its last stage; the next beat is taken once it moves out.
module universal_lagged_rng_generator import ulr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ulr_req_if.sink   i_req,
    ulr_rsp_if.source o_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SEED,
        ST_DIV_IJ,
        ST_DIV_KL,
        ST_DIV_END,
        ST_FILL_MUL,
        ST_FILL_RED,
        ST_CALC,
        ST_SCALE,
        ST_FIN
    } t_state;

    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [4:0]           BIT_LAST   = 5'(FRAC_BITS - 1);
    localparam t_idx                 ENT_LAST   = 7'(LAG_ENTRIES - 1);
    localparam t_idx                 LAG_GAP    = LAG_LAST - SECOND_LAG_INIT;

    // Reduce x (below 256 * m) modulo m by eight compare-subtract steps
    function automatic logic [7:0] f_mod8(input logic [15:0] x, input logic [7:0] m);
        logic [15:0] r;
        logic [15:0] s;
        r = x;
        for (int i = 7; i >= 0; i--) begin
            s = {8'd0, m} << i;
            if (r >= s) begin
                r = r - s;
            end
        end
        return r[7:0];
    endfunction

    function automatic t_idx f_step_back(input t_idx p);
        if (p <= 7'd1 || p > LAG_LAST) begin
            return LAG_LAST;
        end
        return p - 7'd1;
    endfunction

    t_state r_state;
    logic   r_seeded;
    t_frac  r_carry;
    t_idx   r_first;
    t_idx   r_second;

    // Seed split
    t_seed                   r_seed;
    logic [SPLIT_Q_BITS-1:0] r_ij;
    logic [SPLIT_Q_BITS-1:0] r_kl;
    logic [7:0]              r_qij;
    logic [7:0]              r_qkl;
    logic [7:0]              r_a;

    // Table fill loop
    logic [15:0] r_pab;
    logic [15:0] r_t;
    logic [7:0]  r_b;
    logic [7:0]  r_c;
    logic [7:0]  r_d;
    t_frac       r_acc;
    logic [4:0]  r_bit;
    t_idx        r_ent;

    // Result staging
    t_frac                r_u;
    t_upper               r_upper;
    logic [PROD_BITS-1:0] r_prod;
    logic                 r_err;

    // Output register
    logic   r_ovalid;
    t_frac  r_ofrac;
    t_upper r_oscaled;
    logic   r_oerr;

    logic [SEED_BITS+31:0]    split_prod;
    t_seed                    kl_full;
    logic [SPLIT_Q_BITS+15:0] qij_prod;
    logic [SPLIT_Q_BITS+15:0] qkl_prod;
    logic [SPLIT_Q_BITS-1:0]  ij_rem;
    logic [SPLIT_Q_BITS-1:0]  kl_rem;
    logic [7:0]              ij_b;
    logic [7:0]              pab_mod;
    logic [15:0]             t_next;
    logic [15:0]             pab_next;
    logic [15:0]             lcg_lin;
    logic [7:0]              lfg_m;
    logic [11:0]             mix;
    t_frac                   acc_n;
    t_idx                    slot_first;
    t_idx                    slot_second;
    t_frac                   ram_a;
    t_frac                   ram_b;
    t_frac                   lag_diff;
    t_frac                   carry_next;
    t_frac                   draw_u;
    logic [PROD_BITS-1:0]    prod_round;
    t_upper                  scaled_raw;
    t_upper                  scaled_clamp;
    logic                    out_free;
    logic                    out_fire;
    logic                    in_beat;
    logic                    ram_we;
    t_idx                    ram_waddr;
    t_frac                   ram_wdata;

    // Seed split: quotients by reciprocal multiply, remainders by multiply-subtract
    always_comb begin
        split_prod = {32'd0, r_seed} * {{SEED_BITS{1'b0}}, SPLIT_RECIP};
        kl_full    = r_seed - ({15'd0, r_ij} * {15'd0, SEED_SPLIT});
        qij_prod   = {16'd0, r_ij} * {15'd0, IJ_RECIP};
        qkl_prod   = {16'd0, r_kl} * {15'd0, KL_RECIP};
        ij_rem     = r_ij - ({7'd0, r_qij} * {7'd0, SPLIT_IJ});
        kl_rem     = r_kl - ({7'd0, r_qkl} * {7'd0, MOD_LCG});
        ij_b       = ij_rem[7:0] + 8'd2;
    end

    // Fill loop: multiply stage and reduce stage
    always_comb begin
        pab_mod  = f_mod8(r_pab, MOD_LFG);
        t_next   = {8'd0, pab_mod} * {8'd0, r_c};
        pab_next = {8'd0, r_b} * {8'd0, r_c};
        lcg_lin  = {8'd0, LCG_MUL} * {8'd0, r_d} + 16'd1;
        lfg_m    = f_mod8(r_t, MOD_LFG);
        mix      = {6'd0, r_d[5:0]} * {6'd0, lfg_m[5:0]};
        acc_n    = {r_acc[FRAC_BITS-2:0], mix[5]};
    end

    // Draw datapath
    always_comb begin
        slot_first  = r_first - 7'd1;
        slot_second = r_second - 7'd1;
        lag_diff    = ram_a - ram_b;
        if (r_carry < CARRY_DEC) begin
            carry_next = r_carry + (CARRY_MOD - CARRY_DEC);
        end else begin
            carry_next = r_carry - CARRY_DEC;
        end
        draw_u       = lag_diff - carry_next;
        prod_round   = r_prod + ROUND_HALF;
        scaled_raw   = prod_round[FRAC_BITS +: UPPER_BITS];
        scaled_clamp = (scaled_raw > r_upper) ? r_upper : scaled_raw;
    end

    assign out_free = !r_ovalid || o_rsp.ready;
    assign out_fire = (r_state == ST_FIN) && out_free;
    assign in_beat  = i_req.valid && i_req.ready;

    // Table port: fill writes by entry, draws write back the first lag slot
    always_comb begin
        ram_we    = (r_state == ST_CALC) || (r_state == ST_FILL_RED && r_bit == BIT_LAST);
        ram_waddr = (r_state == ST_CALC) ? slot_first : r_ent;
        ram_wdata = (r_state == ST_CALC) ? lag_diff : acc_n;
    end

    ulr_ram #(
        .WIDTH (FRAC_BITS),
        .DEPTH (LAG_ENTRIES)
    ) u_lag_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (slot_first),
        .o_rdata_a (ram_a),
        .i_raddr_b (slot_second),
        .o_rdata_b (ram_b)
    );

    assign i_req.ready            = (r_state == ST_IDLE);
    assign o_rsp.valid            = r_ovalid;
    assign o_rsp.uniform_fraction = r_ofrac;
    assign o_rsp.scaled_integer   = r_oscaled;
    assign o_rsp.error_flag       = r_oerr;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seeded <= 1'b0;
            r_carry  <= '0;
            r_first  <= LAG_LAST;
            r_second <= SECOND_LAG_INIT;
            r_ovalid <= 1'b0;
        end else begin
            // raise the output beat as a result leaves, drop it once taken
            if (out_fire) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_prod <= '0;
                        r_u    <= '0;
                        if (i_req.operation == OP_SEED) begin
                            r_upper <= '0;
                            if (i_req.seed_value > SEED_MAX) begin
                                r_err   <= 1'b1;
                                r_state <= ST_FIN;
                            end else begin
                                r_err   <= 1'b0;
                                r_seed  <= i_req.seed_value;
                                r_state <= ST_DIV_SEED;
                            end
                        end else if (!r_seeded) begin
                            r_upper <= '0;
                            r_err   <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_upper <= i_req.upper_limit;
                            r_err   <= 1'b0;
                            r_state <= ST_CALC;
                        end
                    end
                end

                ST_DIV_SEED: begin
                    // ij is the seed over the split constant
                    r_ij    <= split_prod[SPLIT_SHIFT +: SPLIT_Q_BITS];
                    r_state <= ST_DIV_IJ;
                end

                ST_DIV_IJ: begin
                    r_kl    <= kl_full[SPLIT_Q_BITS-1:0];
                    r_qij   <= qij_prod[SMALL_SHIFT +: 8];
                    r_state <= ST_DIV_KL;
                end

                ST_DIV_KL: begin
                    r_a     <= r_qij + 8'd2;
                    r_b     <= ij_b;
                    r_qkl   <= qkl_prod[SMALL_SHIFT +: 8];
                    r_state <= ST_DIV_END;
                end

                ST_DIV_END: begin
                    r_pab   <= {8'd0, r_a} * {8'd0, r_b};
                    r_c     <= r_qkl + 8'd1;
                    r_d     <= kl_rem[7:0];
                    r_bit   <= '0;
                    r_ent   <= '0;
                    r_state <= ST_FILL_MUL;
                end

                ST_FILL_MUL: begin
                    // next a*b is b*c, known before the new value arrives
                    r_t     <= t_next;
                    r_pab   <= pab_next;
                    r_d     <= f_mod8(lcg_lin, MOD_LCG);
                    r_state <= ST_FILL_RED;
                end

                ST_FILL_RED: begin
                    r_b   <= r_c;
                    r_c   <= lfg_m;
                    r_acc <= acc_n;
                    if (r_bit == BIT_LAST && r_ent == ENT_LAST) begin
                        r_bit    <= '0;
                        r_ent    <= r_ent + 7'd1;
                        r_carry  <= CARRY_INIT;
                        r_first  <= LAG_LAST;
                        r_second <= SECOND_LAG_INIT;
                        r_seeded <= 1'b1;
                        r_state  <= ST_FIN;
                    end else if (r_bit == BIT_LAST) begin
                        r_bit   <= '0;
                        r_ent   <= r_ent + 7'd1;
                        r_state <= ST_FILL_MUL;
                    end else begin
                        r_bit   <= r_bit + 5'd1;
                        r_state <= ST_FILL_MUL;
                    end
                end

                ST_CALC: begin
                    r_carry  <= carry_next;
                    r_first  <= f_step_back(r_first);
                    r_second <= f_step_back(r_second);
                    r_u      <= draw_u;
                    r_state  <= ST_SCALE;
                end

                ST_SCALE: begin
                    r_prod  <= {{UPPER_BITS{1'b0}}, r_u} * {{FRAC_BITS{1'b0}}, r_upper};
                    r_state <= ST_FIN;
                end

                ST_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_ofrac   <= r_u;
                        r_oscaled <= scaled_clamp;
                        r_oerr    <= r_err;
                        r_state   <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_lag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first >= 7'd1 && r_first <= LAG_LAST && r_second >= 7'd1 && r_second <= LAG_LAST)
        else $error("lag position out of range");

    a_lag_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first > r_second) ? (r_first - r_second == LAG_GAP)
                             : (r_second - r_first == LAG_LAST - LAG_GAP))
        else $error("lag positions lost their spacing");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.error_flag |->
            o_rsp.uniform_fraction == '0 && o_rsp.scaled_integer == '0)
        else $error("error beat carries a nonzero value");

    a_seeded_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_seeded))
        else $error("seeded flag dropped without reset");

endmodule

// File: tb/universal_lagged_rng_generator_tb.sv
module universal_lagged_rng_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ulr_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;
    localparam int DRAW_RUN    = 100;
    localparam int MIXED_RUN   = 59;

    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);
    localparam t_upper             UPPER_MAX  = '1;
    localparam t_seed              SEED_ONES  = '1;

    typedef struct {
        t_op    op;
        t_seed  seed;
        t_upper upper;
    } rng_request_t;

    typedef struct {
        t_frac  frac;
        t_upper scaled;
        logic   err;
    } rng_output_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ulr_req_if req_ch ();
    ulr_rsp_if rsp_ch ();

    universal_lagged_rng_generator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Generator state mirrored from the block
    t_frac lag_tab [LAG_ENTRIES] = '{default: '0};
    t_frac carry_q      = '0;
    t_idx  lag_first    = LAG_LAST;
    t_idx  lag_second   = SECOND_LAG_INIT;
    logic  lag_seeded   = 1'b0;

    rng_request_t rng_requests_pending [$];
    rng_output_t  random_outputs_due [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_done     = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;

    // Fold a lag position 1..97 into a table slot
    function automatic int unsigned lag_slot(t_idx pos);
        return (pos == 0 || pos > LAG_LAST) ? 0 : pos - 1;
    endfunction

    function automatic t_idx lag_step_back(t_idx pos);
        return (pos <= 1 || pos > LAG_LAST) ? LAG_LAST : pos - 1'b1;
    endfunction

    // Advance the mirrored generator by one request and return its output beat
    function automatic rng_output_t next_random_output(rng_request_t rq);
        rng_output_t        res;
        int unsigned        ij, kl, a, b, c, d, m, acc;
        int unsigned        s1, s2;
        t_frac              v;
        logic [PROD_BITS:0] prod;
        res.frac   = '0;
        res.scaled = '0;
        res.err    = 1'b0;
        if (rq.op == OP_SEED) begin
            if (rq.seed > SEED_MAX) begin
                res.err = 1'b1;
            end else begin
                // Split the seed, then fill the table MSB first
                ij = 32'(rq.seed) / 32'(SEED_SPLIT);
                kl = 32'(rq.seed) - 32'(SEED_SPLIT) * ij;
                a  = (ij / 32'(SPLIT_IJ)) % 32'(SPLIT_IJ) + 2;
                b  = ij % 32'(SPLIT_IJ) + 2;
                c  = (kl / 32'(MOD_LCG)) % (32'(MOD_LFG) - 1) + 1;
                d  = kl % 32'(MOD_LCG);
                for (int n = 0; n < LAG_ENTRIES; n++) begin
                    acc = 0;
                    for (int k = 0; k < FRAC_BITS; k++) begin
                        m   = (((a * b) % 32'(MOD_LFG)) * c) % 32'(MOD_LFG);
                        a   = b;
                        b   = c;
                        c   = m;
                        d   = (32'(LCG_MUL) * d + 1) % 32'(MOD_LCG);
                        acc = (acc << 1) | (((d * m) % 64) >= 32 ? 1 : 0);
                    end
                    lag_tab[n] = acc[FRAC_BITS-1:0];
                end
                carry_q    = CARRY_INIT;
                lag_first  = LAG_LAST;
                lag_second = SECOND_LAG_INIT;
                lag_seeded = 1'b1;
            end
        end else if (!lag_seeded) begin
            res.err = 1'b1;
        end else begin
            s1 = lag_slot(lag_first);
            s2 = lag_slot(lag_second);
            v  = lag_tab[s1] - lag_tab[s2];
            lag_tab[s1] = v;
            lag_first   = lag_step_back(lag_first);
            lag_second  = lag_step_back(lag_second);
            if (carry_q < CARRY_DEC) begin
                carry_q = carry_q + CARRY_MOD - CARRY_DEC;
            end else begin
                carry_q = carry_q - CARRY_DEC;
            end
            res.frac   = v - carry_q;
            prod       = (PROD_BITS+1)'(res.frac) * (PROD_BITS+1)'(rq.upper) + ROUND_HALF;
            prod       = prod >> FRAC_BITS;
            res.scaled = (prod > (PROD_BITS+1)'(rq.upper)) ? rq.upper
                                                           : prod[UPPER_BITS-1:0];
        end
        return res;
    endfunction

    function automatic t_upper random_upper();
        case ($urandom_range(9))
            0:       return '0;
            1:       return UPPER_MAX;
            2, 3:    return t_upper'($urandom_range(1000));
            default: return t_upper'($urandom);
        endcase
    endfunction

    task automatic queue_request(t_op op, t_seed seed, t_upper upper);
        rng_request_t rq;
        rq.op    = op;
        rq.seed  = seed;
        rq.upper = upper;
        rng_requests_pending.push_back(rq);
    endtask

    task automatic queue_draw(t_upper upper);
        queue_request(OP_DRAW, t_seed'($urandom), upper);
    endtask

    task automatic queue_seed(t_seed seed);
        queue_request(OP_SEED, seed, random_upper());
    endtask

    // Seed, a run long enough to wrap the lag positions, then a mixed tail
    task automatic queue_random_phase();
        int pick;
        queue_seed(t_seed'($urandom_range(SEED_MAX)));
        for (int n = 0; n < DRAW_RUN; n++) begin
            queue_draw(random_upper());
        end
        for (int n = 0; n < MIXED_RUN; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                queue_seed(t_seed'($urandom_range(SEED_MAX)));
            end else if (pick < 12) begin
                queue_seed(t_seed'($urandom_range(SEED_ONES, SEED_MAX + 1)));
            end else begin
                queue_draw(random_upper());
            end
        end
    endtask

    task automatic wait_all_done();
        while (rng_requests_pending.size() > 0 || req_ch.valid
               || random_outputs_due.size() > 0) begin
            @(posedge clk);
        end
    endtask

    // Request driver: predict on each accepted beat, then offer the next one
    always @(posedge clk) begin
        rng_request_t taken;
        rng_request_t nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                taken.op    = req_ch.operation;
                taken.seed  = req_ch.seed_value;
                taken.upper = req_ch.upper_limit;
                random_outputs_due.push_back(next_random_output(taken));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (rng_requests_pending.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                    nxt = rng_requests_pending.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.operation   <= nxt.op;
                    req_ch.seed_value  <= nxt.seed;
                    req_ch.upper_limit <= nxt.upper;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat, drive ready with stalls and long holds
    always @(posedge clk) begin
        rng_output_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (random_outputs_due.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end else begin
                    want = random_outputs_due.pop_front();
                    if (rsp_ch.uniform_fraction !== want.frac) begin
                        $error("uniform_fraction: expected %0d, got %0d",
                               want.frac, rsp_ch.uniform_fraction);
                        mismatches++;
                    end
                    if (rsp_ch.scaled_integer !== want.scaled) begin
                        $error("scaled_integer: expected %0d, got %0d",
                               want.scaled, rsp_ch.scaled_integer);
                        mismatches++;
                    end
                    if (rsp_ch.error_flag !== want.err) begin
                        $error("error_flag: expected %0d, got %0d",
                               want.err, rsp_ch.error_flag);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (holds_done != holds_asked) begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= LONG_HOLD;
                holds_done   <= holds_done + 1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: drop out if neither channel moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("universal_lagged_rng_generator regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_SEED;
        req_ch.seed_value  = '0;
        req_ch.upper_limit = '0;
        rsp_ch.ready       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: draws before seeding, rejected seeds, seed extremes, limits
        queue_draw(UPPER_MAX);
        queue_draw('0);
        queue_seed(SEED_ONES);
        queue_seed(t_seed'(SEED_MAX + 1));
        queue_draw(t_upper'(1000));
        queue_seed('0);
        queue_draw('0);
        queue_draw(UPPER_MAX);
        queue_draw(t_upper'(1));
        queue_draw(t_upper'(1) << (UPPER_BITS - 1));
        queue_seed(t_seed'(SEED_MAX + 1));
        queue_draw(UPPER_MAX);
        queue_seed(SEED_MAX);
        queue_draw(t_upper'(1000));
        queue_draw(t_upper'(29'h1555_5555));
        queue_draw(t_upper'(29'h0AAA_AAAA));
        queue_draw('0);
        queue_seed(t_seed'(1802 * 30082 + 9373));
        queue_draw(UPPER_MAX);
        queue_draw(t_upper'(1));
        queue_draw(t_upper'(255));
        wait_all_done();

        // Random phases with different idle mixes
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_phase();
        // Let the seed finish and the draws get going before the long hold
        while (rng_requests_pending.size() >= DRAW_RUN) begin
            @(posedge clk);
        end
        // Hold the receiver off while the sender keeps offering
        holds_asked = holds_asked + 1;
        wait_all_done();

        send_idle_pct  = 85;
        recv_stall_pct = 0;
        queue_random_phase();
        wait_all_done();

        send_idle_pct  = 0;
        recv_stall_pct = 85;
        queue_random_phase();
        wait_all_done();

        send_idle_pct  = 21;
        recv_stall_pct = 21;
        queue_random_phase();
        wait_all_done();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && random_outputs_due.size() == 0) begin
            $display("universal_lagged_rng_generator regression: pass");
        end else begin
            $display("universal_lagged_rng_generator regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/ulr_pkg.sv
src/ulr_if.sv
src/ulr_ram.sv
src/universal_lagged_rng_generator.sv
tb/universal_lagged_rng_generator_tb.sv
